[design/lad_pkg.sv]
package lad_pkg;

  localparam int LAD_DEPTH  = 8;
  localparam int LAD_DATA_W = 32;
  localparam int LAD_OCC_W  = 4;

  typedef enum logic [1:0] {
    KIND_INS_FRONT = 2'd0,
    KIND_INS_REAR  = 2'd1,
    KIND_REM_FRONT = 2'd2,
    KIND_REM_REAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FRONT_FULL = 2'd1,
    ST_REAR_FULL  = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

[design/lad_cell.sv]
module lad_cell #(
  parameter int W     = 32,
  parameter int DEPTH = 8,
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [W-1:0]             wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  input  logic [W-1:0]             pass_in,
  output logic [W-1:0]             pass_out
);
  localparam int IW = $clog2(DEPTH);

  logic [W-1:0] slot_r;
  logic [W-1:0] pass_r;
  logic         sel;

  assign sel = (rd_idx == IW'(IDX));

  // The selected cell injects its slot into the chain; every other cell
  // forwards what its left neighbor offered in the previous cycle.
  assign pass_out = sel ? slot_r : pass_r;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      slot_r <= wr_data;
    end
    pass_r <= pass_in;
  end

endmodule

[design/linear_array_deque_unit.sv]
// For inserts and failed requests the result is registered at the edge of the
// input transfer, and the next request may follow at once.
// A successful removal shifts the slot value along the chain of cells; its
// result is registered when the S_SCAN count reaches DEPTH - 1, and the input
// is stalled until then.
// A held result stalls the input. A synchronous low rst_n empties the deque.
module linear_array_deque_unit #(
  parameter int DEPTH = lad_pkg::LAD_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_kind,
  input  logic signed [lad_pkg::LAD_DATA_W-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_status,
  output logic signed [lad_pkg::LAD_DATA_W-1:0] out_removed_value,
  output logic [lad_pkg::LAD_OCC_W-1:0]        out_occupancy
);
  import lad_pkg::*;

  localparam int W  = LAD_DATA_W;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = (IW + 1 > LAD_OCC_W) ? IW + 1 : LAD_OCC_W;

  state_t               state_r, state_nxt;
  logic [IW-1:0]        head_r, head_nxt;
  logic [IW-1:0]        tail_r, tail_nxt;
  logic                 empty_r, empty_nxt;
  logic [IW-1:0]        rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [W-1:0]         out_value_r, out_value_nxt;
  logic [LAD_OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic                 accept;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic [CW-1:0]        occ_full;
  kind_t                kind;
  logic [W-1:0]         chain [DEPTH+1];

  assign kind     = kind_t'(in_kind);
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lad_cell #(
      .W     (W),
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_data  (in_value),
      .rd_idx   (rd_idx_r),
      .pass_in  (chain[i]),
      .pass_out (chain[i+1])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    rd_idx_nxt     = rd_idx_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_idx         = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_status_nxt = ST_DONE;
          out_value_nxt  = '0;
          case (kind)
            KIND_INS_FRONT, KIND_INS_REAR: begin
              out_valid_nxt = 1'b1;
              if (empty_r) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                empty_nxt = 1'b0;
                wr_en     = 1'b1;
                wr_idx    = '0;
              end else if (kind == KIND_INS_FRONT) begin
                if (head_r == '0) begin
                  out_status_nxt = ST_FRONT_FULL;
                end else begin
                  head_nxt = head_r - 1'b1;
                  wr_en    = 1'b1;
                  wr_idx   = head_r - 1'b1;
                end
              end else begin
                if (tail_r == IW'(DEPTH - 1)) begin
                  out_status_nxt = ST_REAR_FULL;
                end else begin
                  tail_nxt = tail_r + 1'b1;
                  wr_en    = 1'b1;
                  wr_idx   = tail_r + 1'b1;
                end
              end
            end
            default: begin
              if (empty_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                // The slot value reaches the end of the chain while the
                // indices already hold their post-removal values.
                rd_idx_nxt = (kind == KIND_REM_FRONT) ? head_r : tail_r;
                cnt_nxt    = '0;
                state_nxt  = S_SCAN;
                if (head_r == tail_r) begin
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  empty_nxt = 1'b1;
                end else if (kind == KIND_REM_FRONT) begin
                  head_nxt = head_r + 1'b1;
                end else begin
                  tail_nxt = tail_r - 1'b1;
                end
              end
            end
          endcase
          out_occ_nxt = occ_full[LAD_OCC_W-1:0];
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IW'(DEPTH - 1)) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = chain[DEPTH];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign occ_full = empty_nxt ? '0
                  : (CW'(tail_nxt) - CW'(head_nxt) + CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_value_r;
  assign out_occupancy     = out_occ_r;

endmodule
